// ===== rtl/clt_pkg.sv =====
// Package for the command line tokenizer: byte classes, scan states and the step table.
`default_nettype none

package clt_pkg;

  // Byte classes.
  typedef logic [2:0] byte_class_t;
  localparam byte_class_t CLS_PLAIN  = 3'd0;
  localparam byte_class_t CLS_BLANK  = 3'd1;
  localparam byte_class_t CLS_BSLASH = 3'd2;
  localparam byte_class_t CLS_DQ     = 3'd3;
  localparam byte_class_t CLS_END    = 3'd4;
  localparam byte_class_t CLS_SQ     = 3'd5;
  localparam int unsigned NUM_CLASSES = 6;

  // Scan states; DONE and EMPTY_END are final and never held.
  typedef logic [3:0] scan_state_t;
  localparam scan_state_t ST_START     = 4'd0;
  localparam scan_state_t ST_DQUOTE    = 4'd1;
  localparam scan_state_t ST_DQ_ESC    = 4'd2;
  localparam scan_state_t ST_WORD      = 4'd3;
  localparam scan_state_t ST_ESC       = 4'd4;
  localparam scan_state_t ST_DONE      = 4'd5;
  localparam scan_state_t ST_SQUOTE    = 4'd6;
  localparam scan_state_t ST_SQ_ESC    = 4'd7;
  localparam scan_state_t ST_EMPTY_END = 4'd8;
  localparam int unsigned NUM_STATES   = 9;

  // Special characters.
  localparam logic [7:0] CHAR_EOS    = 8'h00;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_DQ     = 8'h22;
  localparam logic [7:0] CHAR_SQ     = 8'h27;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;

  // One table entry: keep flag and next state.
  typedef struct packed {
    logic        keep;
    scan_state_t next;
  } step_t;

  // Rows are states, columns are byte classes in the order listed above.
  localparam step_t STEP_TABLE [NUM_STATES][NUM_CLASSES] = '{
    '{ '{1'b1, ST_WORD},   '{1'b0, ST_START},  '{1'b0, ST_ESC},
       '{1'b0, ST_DQUOTE}, '{1'b0, ST_EMPTY_END}, '{1'b0, ST_SQUOTE} },
    '{ '{1'b1, ST_DQUOTE}, '{1'b1, ST_DQUOTE}, '{1'b0, ST_DQ_ESC},
       '{1'b0, ST_WORD},   '{1'b0, ST_DONE},   '{1'b1, ST_DQUOTE} },
    '{ '{1'b1, ST_DQUOTE}, '{1'b1, ST_DQUOTE}, '{1'b1, ST_DQUOTE},
       '{1'b1, ST_DQUOTE}, '{1'b0, ST_DONE},   '{1'b1, ST_DQUOTE} },
    '{ '{1'b1, ST_WORD},   '{1'b0, ST_DONE},   '{1'b0, ST_ESC},
       '{1'b0, ST_DQUOTE}, '{1'b0, ST_DONE},   '{1'b0, ST_SQUOTE} },
    '{ '{1'b1, ST_WORD},   '{1'b1, ST_WORD},   '{1'b1, ST_WORD},
       '{1'b1, ST_WORD},   '{1'b0, ST_DONE},   '{1'b1, ST_WORD} },
    '{ '{1'b0, ST_START},  '{1'b0, ST_START},  '{1'b0, ST_START},
       '{1'b0, ST_START},  '{1'b0, ST_START},  '{1'b0, ST_START} },
    '{ '{1'b1, ST_SQUOTE}, '{1'b1, ST_SQUOTE}, '{1'b0, ST_SQ_ESC},
       '{1'b1, ST_SQUOTE}, '{1'b0, ST_DONE},   '{1'b0, ST_WORD} },
    '{ '{1'b1, ST_SQUOTE}, '{1'b1, ST_SQUOTE}, '{1'b1, ST_SQUOTE},
       '{1'b1, ST_SQUOTE}, '{1'b0, ST_DONE},   '{1'b1, ST_SQUOTE} },
    '{ '{1'b0, ST_START},  '{1'b0, ST_START},  '{1'b0, ST_START},
       '{1'b0, ST_START},  '{1'b0, ST_START},  '{1'b0, ST_START} }
  };

  // Sort a byte into its class.
  function automatic byte_class_t classify(input logic [7:0] c);
    byte_class_t cls;
    priority if (c == CHAR_EOS)                        cls = CLS_END;
    else if (c == CHAR_BSLASH)                         cls = CLS_BSLASH;
    else if (c == CHAR_DQ)                             cls = CLS_DQ;
    else if (c == CHAR_SQ)                             cls = CLS_SQ;
    else if (c == CHAR_SPACE || c == CHAR_TAB)         cls = CLS_BLANK;
    else                                               cls = CLS_PLAIN;
    return cls;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/command_line_tokenizer_unit.sv =====
// Command line tokenizer: input register, table step and result register.
//
// Usage: one byte of a command line enters per request on the s_ channel
// (s_tdata[7:0]); byte 0 ends the line. Each byte gives one result request on
// the m_ channel: the byte echoed, whether it is argument text, whether a
// non-empty argument ends on it, and the index of the argument it belongs to.
// m_tlast is high on the byte that ends the line.
// An accepted byte passes through the input register, then the result register,
// before it appears on m_. Throughput is one byte per cycle while the receiver
// takes results; the scan state loop is a single table lookup, updated when a byte
// moves from the input register into the result register.
// Reset (rst, synchronous) empties both registers and returns the scanner to
// the start of a line with argument index 0.
// When the receiver holds m_tready low, the result register holds its request
// and the input register still takes one more byte; s_tready then falls until
// the result is taken.
`default_nettype none

module command_line_tokenizer_unit
  import clt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Input channel.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,  // [7:0] in_byte
  // Result channel.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,  // [7:0] out_byte, [8] byte_kept, [9] token_end,
                                     // [17:10] token_index, [23:18] zero
  output logic             m_tlast   // line_end
);

  // Input register.
  logic       in_valid;
  logic [7:0] in_byte;

  // Scanner state.
  scan_state_t scan_state, scan_state_next;
  logic        token_has_text, token_has_text_next;
  logic        discard_rest, discard_rest_next;
  logic [7:0]  token_counter, token_counter_next;

  // Result register.
  logic       out_valid;
  logic [7:0] out_byte;
  logic       byte_kept;
  logic       token_end;
  logic       line_end;
  logic [7:0] token_index;

  // Step logic signals.
  logic        advance;
  byte_class_t cls;
  scan_state_t cur_state;
  step_t       entry;
  logic        is_final;
  logic        has_text;
  logic        kept_c;
  logic        tend_c;

  // Handshakes: the result register frees when empty or taken.
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  // Classify and look up the table; stray states act as the start state.
  always_comb begin
    cls = classify(in_byte);
    if (scan_state >= scan_state_t'(NUM_STATES) || scan_state == ST_DONE ||
        scan_state == ST_EMPTY_END) begin
      cur_state = ST_START;
    end else begin
      cur_state = scan_state;
    end
    entry    = STEP_TABLE[cur_state][cls];
    is_final = (entry.next == ST_DONE) || (entry.next == ST_EMPTY_END);
    kept_c   = !discard_rest && entry.keep;
    has_text = token_has_text || entry.keep;
    tend_c   = !discard_rest && is_final && has_text;
  end

  // Next scanner state.
  always_comb begin
    scan_state_next     = scan_state;
    token_has_text_next = token_has_text;
    discard_rest_next   = discard_rest;
    token_counter_next  = token_counter;
    if (cls == CLS_END) begin
      scan_state_next     = ST_START;
      token_has_text_next = 1'b0;
      discard_rest_next   = 1'b0;
      token_counter_next  = 8'd0;
    end else if (!discard_rest) begin
      if (is_final) begin
        scan_state_next     = ST_START;
        token_has_text_next = 1'b0;
        if (has_text) begin
          if (token_counter != 8'hFF) begin
            token_counter_next = token_counter + 8'd1;
          end
        end else begin
          discard_rest_next = 1'b1;
        end
      end else begin
        scan_state_next     = entry.next;
        token_has_text_next = has_text;
      end
    end
  end

  // Scanner state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state     <= ST_START;
      token_has_text <= 1'b0;
      discard_rest   <= 1'b0;
      token_counter  <= 8'd0;
    end else if (advance && in_valid) begin
      scan_state     <= scan_state_next;
      token_has_text <= token_has_text_next;
      discard_rest   <= discard_rest_next;
      token_counter  <= token_counter_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
    if (advance && in_valid) begin
      out_byte    <= in_byte;
      byte_kept   <= kept_c;
      token_end   <= tend_c;
      line_end    <= (cls == CLS_END);
      token_index <= token_counter;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, token_index, token_end, byte_kept, out_byte};
  assign m_tlast  = line_end;

  // While discarding, the scanner rests at the start with no text.
  assert property (@(posedge clk) disable iff (rst)
    discard_rest |-> (scan_state == ST_START && !token_has_text))
    else $error("scanner not idle while discarding");

  // A final state is never held.
  assert property (@(posedge clk) disable iff (rst)
    (scan_state != ST_DONE && scan_state != ST_EMPTY_END &&
     scan_state < scan_state_t'(NUM_STATES)))
    else $error("scanner holds a final or undefined state");

  // An end-of-line byte returns the scanner to its reset state.
  assert property (@(posedge clk) disable iff (rst)
    (advance && in_valid && cls == CLS_END) |=>
      (token_counter == 8'd0 && !discard_rest && !token_has_text &&
       scan_state == ST_START))
    else $error("line end did not clear the scanner");

  // Nothing is kept or ended while the rest of the line is discarded.
  assert property (@(posedge clk) disable iff (rst)
    (advance && in_valid && discard_rest) |=> (!byte_kept && !token_end))
    else $error("output while discarding");

endmodule

`default_nettype wire

// ===== test/command_line_tokenizer_unit_tb.sv =====
// Testbench for the command line tokenizer: random command lines checked against a predictor.
`timescale 1ns / 100ps

module command_line_tokenizer_unit_tb;
  import clt_pkg::*;

  // One result request as the tokenizer should present it.
  typedef struct {
    logic [7:0] out_byte;
    logic       byte_kept;
    logic       token_end;
    logic       line_end;
    logic [7:0] token_index;
  } token_result_t;

  // Tracks the scanner state of the line being fed and holds the results still owed.
  class token_scoreboard;
    scan_state_t   scan_state;
    logic          has_text;
    logic          discarding;
    logic [7:0]    arg_count;
    token_result_t owed_results[$];
    int            errors;
    int            checked;
    int            args_ended;
    int            lines_ended;
    int            lines_discarded;
    int            top_index;

    function new();
      clear_line();
      errors = 0;
      checked = 0;
      args_ended = 0;
      lines_ended = 0;
      lines_discarded = 0;
      top_index = 0;
    endfunction

    function void clear_line();
      scan_state = ST_START;
      has_text = 1'b0;
      discarding = 1'b0;
      arg_count = 8'd0;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    function byte_class_t class_of(input logic [7:0] c);
      case (c)
        CHAR_EOS:              return CLS_END;
        CHAR_BSLASH:           return CLS_BSLASH;
        CHAR_DQ:               return CLS_DQ;
        CHAR_SQ:               return CLS_SQ;
        CHAR_SPACE, CHAR_TAB:  return CLS_BLANK;
        default:               return CLS_PLAIN;
      endcase
    endfunction

    // Quoting and escape transitions; final and unknown states behave as the start state.
    function void scan_step(input scan_state_t s, input byte_class_t cls,
                            output logic keep, output scan_state_t nxt);
      keep = 1'b0;
      nxt = ST_START;
      case (s)
        ST_DQUOTE: begin
          case (cls)
            CLS_BSLASH: nxt = ST_DQ_ESC;
            CLS_DQ:     nxt = ST_WORD;
            CLS_END:    nxt = ST_DONE;
            default: begin
              keep = 1'b1;
              nxt = ST_DQUOTE;
            end
          endcase
        end
        ST_DQ_ESC, ST_ESC, ST_SQ_ESC: begin
          if (cls == CLS_END) begin
            nxt = ST_DONE;
          end else begin
            keep = 1'b1;
            nxt = (s == ST_DQ_ESC) ? ST_DQUOTE : (s == ST_ESC) ? ST_WORD : ST_SQUOTE;
          end
        end
        ST_WORD: begin
          case (cls)
            CLS_PLAIN: begin
              keep = 1'b1;
              nxt = ST_WORD;
            end
            CLS_BLANK, CLS_END: nxt = ST_DONE;
            CLS_BSLASH:         nxt = ST_ESC;
            CLS_DQ:             nxt = ST_DQUOTE;
            default:            nxt = ST_SQUOTE;
          endcase
        end
        ST_SQUOTE: begin
          case (cls)
            CLS_BSLASH: nxt = ST_SQ_ESC;
            CLS_SQ:     nxt = ST_WORD;
            CLS_END:    nxt = ST_DONE;
            default: begin
              keep = 1'b1;
              nxt = ST_SQUOTE;
            end
          endcase
        end
        default: begin
          case (cls)
            CLS_PLAIN: begin
              keep = 1'b1;
              nxt = ST_WORD;
            end
            CLS_BLANK:  nxt = ST_START;
            CLS_BSLASH: nxt = ST_ESC;
            CLS_DQ:     nxt = ST_DQUOTE;
            CLS_END:    nxt = ST_EMPTY_END;
            default:    nxt = ST_SQUOTE;
          endcase
        end
      endcase
    endfunction

    // An accepted byte: advance the scanner and queue the result it owes.
    function void note_request(input logic [7:0] c);
      byte_class_t   cls;
      logic          keep;
      scan_state_t   nxt;
      token_result_t r;
      cls = class_of(c);
      r.out_byte = c;
      r.byte_kept = 1'b0;
      r.token_end = 1'b0;
      r.line_end = 1'b0;
      r.token_index = arg_count;
      if (arg_count > top_index) top_index = arg_count;
      if (!discarding) begin
        scan_step(scan_state, cls, keep, nxt);
        r.byte_kept = keep;
        if (keep) has_text = 1'b1;
        if (nxt == ST_DONE || nxt == ST_EMPTY_END) begin
          if (has_text) begin
            r.token_end = 1'b1;
            args_ended++;
            if (arg_count != 8'd255) arg_count = arg_count + 8'd1;
          end else if (cls != CLS_END) begin
            discarding = 1'b1;
            lines_discarded++;
          end
          has_text = 1'b0;
          scan_state = ST_START;
        end else begin
          scan_state = nxt;
        end
      end
      if (cls == CLS_END) begin
        r.line_end = 1'b1;
        lines_ended++;
        clear_line();
      end
      owed_results.push_back(r);
    endfunction

    function void field_check(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    // A result request taken from the block: compare it with the oldest owed result.
    function void check_result(input logic [23:0] data, input logic last);
      token_result_t r;
      checked++;
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual data %0h last %0b",
                 $time, data, last);
        return;
      end
      r = owed_results.pop_front();
      field_check("out_byte", r.out_byte, data[7:0]);
      field_check("byte_kept", {7'd0, r.byte_kept}, {7'd0, data[8]});
      field_check("token_end", {7'd0, r.token_end}, {7'd0, data[9]});
      field_check("token_index", r.token_index, data[17:10]);
      field_check("padding", 8'd0, {2'd0, data[23:18]});
      field_check("line_end", {7'd0, r.line_end}, {7'd0, last});
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tlast;

  token_scoreboard sb = new();
  logic [7:0]      line_q[$];
  int              bytes_sent = 0;
  bit              quiet = 1'b0;
  bit              hold_sink = 1'b0;

  command_line_tokenizer_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Safety net against a hung run.
  initial begin
    #2ms;
    $display("Timed out with %0d results still owed.", sb.pending());
    $display("== FAIL ==");
    $finish;
  end

  // Result side: random stalls, one long hold-off on request, none near the end.
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_sink) begin
        m_tready <= 1'b0;
        repeat (60) @(negedge clk);
        hold_sink = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Take result requests at the rising edge.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
    end
  end

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    while (c == CHAR_TAB || c == CHAR_SPACE || c == CHAR_DQ || c == CHAR_SQ || c == CHAR_BSLASH)
      c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  function automatic logic [7:0] blank_char();
    return ($urandom_range(0, 1) == 0) ? CHAR_SPACE : CHAR_TAB;
  endfunction

  // One piece of an argument: bare text, a quoted run or an escaped byte.
  function automatic void add_piece();
    logic [7:0] quote;
    case ($urandom_range(0, 4))
      0: repeat ($urandom_range(1, 5)) line_q.push_back(plain_char());
      1, 2: begin
        quote = ($urandom_range(0, 1) == 0) ? CHAR_DQ : CHAR_SQ;
        line_q.push_back(quote);
        repeat ($urandom_range(1, 5)) begin
          case ($urandom_range(0, 4))
            0: begin
              line_q.push_back(CHAR_BSLASH);
              line_q.push_back(8'($urandom_range(1, 255)));
            end
            1: line_q.push_back(blank_char());
            2: line_q.push_back((quote == CHAR_DQ) ? CHAR_SQ : CHAR_DQ);
            default: line_q.push_back(plain_char());
          endcase
        end
        line_q.push_back(quote);
      end
      3: begin
        line_q.push_back(CHAR_BSLASH);
        line_q.push_back(8'($urandom_range(1, 255)));
      end
      default: line_q.push_back(plain_char());
    endcase
  endfunction

  // Mostly well-formed command lines; some noise, some cut off inside a quote or escape.
  function automatic void build_line();
    int kind;
    int ntok;
    line_q.delete();
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      if ($urandom_range(0, 3) == 0) line_q.push_back(blank_char());
      ntok = $urandom_range(1, 6);
      for (int t = 0; t < ntok; t++) begin
        if ($urandom_range(0, 24) == 0) begin
          // Empty quoted argument: the rest of the line is ignored.
          line_q.push_back(($urandom_range(0, 1) == 0) ? CHAR_DQ : CHAR_SQ);
          line_q.push_back(line_q[$]);
        end else begin
          repeat ($urandom_range(1, 3)) add_piece();
        end
        if (t < ntok - 1 || $urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 2)) line_q.push_back(blank_char());
      end
      if (kind == 1) begin
        case ($urandom_range(0, 2))
          0: line_q.push_back(CHAR_DQ);
          1: line_q.push_back(CHAR_SQ);
          default: line_q.push_back(CHAR_BSLASH);
        endcase
        if ($urandom_range(0, 1) == 0) line_q.push_back(CHAR_BSLASH);
      end
    end
    line_q.push_back(CHAR_EOS);
  endfunction

  // Offer one byte, with an optional gap first; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b);
    if (!quiet && !hold_sink && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      s_tdata <= 8'($urandom);
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i]);
  endtask

  // Stop offering and wait until every owed result has been taken.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Stimulus.
  initial begin
    bit saturated;
    bit held;
    bit paused;
    saturated = 1'b0;
    held = 1'b0;
    paused = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'd0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Blanks, an escaped blank and the top byte value.
    line_q = '{"a", CHAR_SPACE, CHAR_TAB, "b", CHAR_BSLASH, CHAR_SPACE, "c", 8'hFF, CHAR_EOS};
    send_line();
    // Escaped quote inside double quotes, then single quotes with an escape inside.
    line_q = '{CHAR_DQ, CHAR_BSLASH, CHAR_DQ, CHAR_SPACE, CHAR_DQ, CHAR_SQ, 8'h80,
               CHAR_BSLASH, CHAR_SQ, CHAR_SQ, CHAR_EOS};
    send_line();
    // Empty argument: what follows on the line is ignored.
    line_q = '{CHAR_DQ, CHAR_DQ, CHAR_SPACE, "z", CHAR_EOS};
    send_line();

    while (bytes_sent < 1100) begin
      if (!saturated && bytes_sent >= 300) begin
        // Enough arguments on one line to saturate the argument index.
        saturated = 1'b1;
        line_q.delete();
        repeat (258) begin
          line_q.push_back(plain_char());
          line_q.push_back(CHAR_SPACE);
        end
        line_q.push_back(CHAR_EOS);
      end else begin
        build_line();
      end
      if (!held && bytes_sent >= 150) begin
        held = 1'b1;
        hold_sink = 1'b1;
      end
      if (!paused && bytes_sent >= 900) begin
        paused = 1'b1;
        wait_drained();
      end
      if (bytes_sent >= 960) quiet = 1'b1;
      send_line();
    end
    s_tvalid <= 1'b0;

    wait_drained();
    repeat (8) @(negedge clk);
    $display("Sent %0d bytes in %0d lines; %0d arguments ended, %0d lines cut short.",
             bytes_sent, sb.lines_ended, sb.args_ended, sb.lines_discarded);
    $display("Checked %0d results; highest argument index %0d.", sb.checked, sb.top_index);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
